>>> rtl/kwm_pkg.sv
// Shared types and constants for the k-way merge selector.
`default_nettype none
package kwm_pkg;

    localparam int DEF_MAX_STREAMS = 8;
    localparam int SID_W           = 3;
    localparam int CFG_W           = 4;
    localparam int USER_W          = 8;

    typedef enum logic [1:0] {
        ST_RECORD  = 2'd0,
        ST_DRAINED = 2'd1,
        ST_REJECT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    // Record header, undo position in the lowest bits.
    typedef struct packed {
        logic [15:0] tuple_len;
        logic [15:0] key_len;
        logic [7:0]  op;
        logic [31:0] seq;
        logic [63:0] undo;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic found;
        logic missing;
        t_rec rec;
    } t_scan;

endpackage
`default_nettype wire

>>> rtl/kwm_cell.sv
// One stream head slot and one stage of the minimum scan chain.
`default_nettype none
module kwm_cell
    import kwm_pkg::*;
#(
    parameter int MAX_STREAMS = DEF_MAX_STREAMS,
    parameter int IDX         = 0,
    parameter int N_W         = CFG_W,
    parameter int IW          = 3
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [N_W-1:0] i_n,
    input  wire logic           i_wr,
    input  wire logic           i_eos,
    input  wire t_rec           i_rec,
    input  wire logic           i_clr,
    input  wire t_scan          i_tok,
    input  wire logic [IW-1:0]  i_tok_idx,
    output t_scan               o_tok,
    output logic [IW-1:0]       o_tok_idx,
    output logic                o_busy
);

    logic          r_valid;
    logic          r_done;
    t_rec          r_rec;
    t_scan         r_tok;
    logic [IW-1:0] r_tok_idx;

    t_scan         n_tok;
    logic [IW-1:0] n_tok_idx;
    logic          in_use;
    logic          cand;
    logic          better;

    always_comb begin
        in_use = (N_W'(IDX) < i_n) && (IDX < MAX_STREAMS);
        cand   = in_use && r_valid;
        better = !i_tok.found
              || (r_rec.undo < i_tok.rec.undo)
              || ((r_rec.undo == i_tok.rec.undo) && (r_rec.seq < i_tok.rec.seq));
        n_tok         = i_tok;
        n_tok_idx     = i_tok_idx;
        n_tok.found   = i_tok.found | cand;
        n_tok.missing = i_tok.missing | (in_use && !r_valid && !r_done);
        if (cand && better) begin
            n_tok.rec = r_rec;
            n_tok_idx = IW'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_done      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr) begin
                if (i_eos) begin
                    r_done <= 1'b1;
                end else begin
                    r_valid <= 1'b1;
                end
            end else if (i_clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !i_eos) begin
            r_rec <= i_rec;
        end
        r_tok_idx <= n_tok_idx;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;
    assign o_busy    = r_valid | r_done;

endmodule
`default_nettype wire

>>> rtl/kway_merge_min_select.sv
// Top level of the k-way merge selector.
// Each request refills or ends one stream's head slot. An accepted request
// that passes the slot check starts a scan token down a chain of
// MAX_STREAMS head cells, one cell per cycle; the token collects the least
// (undo position, sequence, stream) head and whether any in-use stream still
// lacks a head without having ended. A request that yields a result waits for
// the output register to empty before the next acceptance. Head slots and end
// marks clear at reset with no clearing pass; streams_in_use resets to 1 and
// is written through i_cfg_we / i_cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce.
`default_nettype none
module kway_merge_min_select
    import kwm_pkg::*;
#(
    parameter int MAX_STREAMS = DEF_MAX_STREAMS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // undo_position, sequence_req, op_kind, key_length, tuple_length
    input  wire logic [REC_W-1:0]   i_s_axis_tdata,
    // stream_id, end_of_stream, zero fill
    input  wire logic [USER_W-1:0]  i_s_axis_tuser,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // out_undo_position, out_sequence, out_op_kind, out_key_length,
    // out_tuple_length
    output logic [REC_W-1:0]        o_m_axis_tdata,
    // status, from_stream, zero fill
    output logic [USER_W-1:0]       o_m_axis_tuser
);

    localparam int NW  = $clog2(MAX_STREAMS + 1);
    localparam int N_W = (NW > CFG_W) ? NW : CFG_W;
    localparam int IW  = $clog2(MAX_STREAMS);

    t_state               r_state;
    t_state               n_state;
    logic [CFG_W-1:0]     r_streams;
    logic                 r_drained;
    logic                 n_drained;
    logic                 r_start;
    logic                 n_start;
    t_status              r_res_status;
    t_status              n_res_status;
    logic [SID_W-1:0]     r_res_from;
    logic [SID_W-1:0]     n_res_from;
    t_rec                 r_res_rec;
    t_rec                 n_res_rec;
    logic                 r_ovalid;
    t_status              r_ostatus;
    logic [SID_W-1:0]     r_ofrom;
    t_rec                 r_orec;

    logic                 out_ld;
    logic                 clr_any;
    logic                 acc;
    logic                 reject;
    logic                 busy;
    logic [N_W-1:0]       n_eff;
    logic [N_W-1:0]       cfg_ext;
    logic [SID_W-1:0]     sid;
    logic                 eos;
    t_rec                 in_rec;

    t_scan                tok     [0:MAX_STREAMS];
    logic [IW-1:0]        tok_idx [0:MAX_STREAMS];
    logic [MAX_STREAMS-1:0] cell_busy;
    logic [MAX_STREAMS-1:0] cell_wr;
    logic [MAX_STREAMS-1:0] cell_clr;

    assign sid    = i_s_axis_tuser[SID_W-1:0];
    assign eos    = i_s_axis_tuser[SID_W];
    assign in_rec = i_s_axis_tdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        cfg_ext = N_W'(r_streams);
        if (cfg_ext == '0) begin
            n_eff = N_W'(1);
        end else if (cfg_ext > N_W'(MAX_STREAMS)) begin
            n_eff = N_W'(MAX_STREAMS);
        end else begin
            n_eff = cfg_ext;
        end
    end

    always_comb begin
        busy = 1'b0;
        for (int i = 0; i < MAX_STREAMS; i++) begin
            if (N_W'(sid) == N_W'(i)) begin
                busy = busy | cell_busy[i];
            end
        end
        reject = (N_W'(sid) >= n_eff) || busy;
    end

    assign tok[0].valid   = r_start;
    assign tok[0].found   = 1'b0;
    assign tok[0].missing = 1'b0;
    assign tok[0].rec     = '0;
    assign tok_idx[0]     = '0;

    for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
        assign cell_wr[g]  = acc && !reject && (N_W'(sid) == N_W'(g));
        assign cell_clr[g] = clr_any && (tok_idx[MAX_STREAMS] == IW'(g));
        kwm_cell #(
            .MAX_STREAMS (MAX_STREAMS),
            .IDX         (g),
            .N_W         (N_W),
            .IW          (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_n       (n_eff),
            .i_wr      (cell_wr[g]),
            .i_eos     (eos),
            .i_rec     (in_rec),
            .i_clr     (cell_clr[g]),
            .i_tok     (tok[g]),
            .i_tok_idx (tok_idx[g]),
            .o_tok     (tok[g+1]),
            .o_tok_idx (tok_idx[g+1]),
            .o_busy    (cell_busy[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_start      = 1'b0;
        n_drained    = r_drained;
        n_res_status = r_res_status;
        n_res_from   = r_res_from;
        n_res_rec    = r_res_rec;
        out_ld       = 1'b0;
        clr_any      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (reject) begin
                        n_res_status = ST_REJECT;
                        n_res_from   = sid;
                        n_res_rec    = '0;
                        n_state      = S_EMIT;
                    end else begin
                        n_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (tok[MAX_STREAMS].valid) begin
                    if (tok[MAX_STREAMS].missing) begin
                        n_state = S_IDLE;
                    end else if (tok[MAX_STREAMS].found) begin
                        n_res_status = ST_RECORD;
                        n_res_from   = SID_W'(tok_idx[MAX_STREAMS]);
                        n_res_rec    = tok[MAX_STREAMS].rec;
                        clr_any      = 1'b1;
                        n_state      = S_EMIT;
                    end else if (!r_drained) begin
                        n_res_status = ST_DRAINED;
                        n_res_from   = '0;
                        n_res_rec    = '0;
                        n_drained    = 1'b1;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    out_ld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streams <= CFG_W'(1);
            r_drained <= 1'b0;
            r_start   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_drained <= n_drained;
            r_start   <= n_start;
            if (i_cfg_we) begin
                r_streams <= i_cfg_wdata;
            end
            if (out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_from   <= n_res_from;
        r_res_rec    <= n_res_rec;
        if (out_ld) begin
            r_ostatus <= r_res_status;
            r_ofrom   <= r_res_from;
            r_orec    <= r_res_rec;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_orec;
    assign o_m_axis_tuser  = USER_W'({r_ofrom, r_ostatus});

endmodule
`default_nettype wire

>>> rtl/kwm_chk.sv
// Port-level checks for the k-way merge selector, bound to the top level.
`default_nettype none
module kwm_chk
    import kwm_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_axis_tvalid,
    input wire logic               o_s_axis_tready,
    input wire logic               o_m_axis_tvalid,
    input wire logic               i_m_axis_tready,
    input wire logic [REC_W-1:0]   o_m_axis_tdata,
    input wire logic [USER_W-1:0]  o_m_axis_tuser
);

    logic [1:0] status;

    assign status = o_m_axis_tuser[1:0];

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output valid or input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> status != 2'd3)
        else $error("undefined status code");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (status == ST_REJECT || status == ST_DRAINED)
            |-> o_m_axis_tdata == '0)
        else $error("reject or drained result carries record data");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted on back-to-back cycles");

endmodule

bind kway_merge_min_select kwm_chk u_kwm_chk (.*);
`default_nettype wire
